// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rwm assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rwm assertion failed");

`endif

// ===== hw/rtl/rwm_pkg.sv =====
// Types and fixed widths for the rolling window mean unit.
// No dependencies; imported by the top level and the checker.
package rwm_pkg;

    localparam int VAL_W  = 32;                // Q16.16 sample and mean
    localparam int SUM_W  = 40;                // Q24.16 running sum
    localparam int CFG_W  = 9;                 // window length register
    localparam int ITER_W = $clog2(SUM_W);     // divider step counter

    typedef struct packed {
        logic             miss;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/rolling_window_mean_unit.sv =====
// Rolling window mean: sample store in a one-port-read/one-port-write memory,
// running sum and count updated per request, restoring divider for the mean.
// Depends on rwm_pkg.
// Steps: accept while idle, update of sum and count, the 40-step bit-serial divider
// (skipped when the mean is missing), then done until the result is taken. A new
// request is accepted only once the unit is idle again, after the result is loaded.
// Reset (i_rst_n low, synchronous) clears sum, counts, write position and sets
// the window length to 1; the sample store is not cleared (never read unwritten).
module rolling_window_mean_unit #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rwm_pkg::CFG_W-1:0]   i_cfg_wdata,   // window_length
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rwm_pkg::VAL_W-1:0]   s_axis_tdata,  // [31:0] sample_value
    input  logic                        s_axis_tuser,  // [0] sample_missing
    input  logic                        s_axis_tlast,  // series_last
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rwm_pkg::VAL_W-1:0]   m_axis_tdata,  // [31:0] mean_value
    output logic                        m_axis_tuser   // [0] mean_missing
);
    import rwm_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PW    = AW + 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);

    // sample store
    t_entry r_mem [MAX_WINDOW];
    t_entry r_rd;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_wp;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_seen;
    logic [CNT_W-1:0]   r_win;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_data;
    logic               r_out_miss;

    t_entry             r_in;
    logic               r_last;
    logic               r_do_leave;
    logic [SUM_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_den;
    logic [ITER_W-1:0]  r_iter;
    logic               r_neg;
    logic               r_res_miss;

    logic               accept;
    logic [CNT_W-1:0]   n_win;
    logic [PW-1:0]      leave_sum;
    logic [AW-1:0]      rd_addr;
    logic [SUM_W-1:0]   in_ext;
    logic [SUM_W-1:0]   n_sum_in;
    logic [CNT_W-1:0]   seen_inc;
    logic [CNT_W-1:0]   n_seen;
    logic               take;
    logic [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]   n_cnt;
    logic               n_res_miss;
    logic [SUM_W-1:0]   n_mag;
    logic [AW-1:0]      n_wp;
    logic [CNT_W:0]     shifted;
    logic [CNT_W:0]     diff;
    logic               ge;
    logic [VAL_W-1:0]   n_mean;
    logic               load_out;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_miss;

    // clamp the written window length into 1..MAX_WINDOW
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_win = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_WINDOW)) begin
            n_win = CNT_W'(MAX_WINDOW);
        end else begin
            n_win = CNT_W'(i_cfg_wdata);
        end
    end

    // entry leaving the window: (wp - win) mod MAX_WINDOW
    always_comb begin
        leave_sum = PW'(r_wp) + PW'(MAX_WINDOW) - PW'(r_win);
        if (leave_sum >= PW'(MAX_WINDOW)) begin
            leave_sum = leave_sum - PW'(MAX_WINDOW);
        end
        rd_addr = leave_sum[AW-1:0];
    end

    // add the incoming sample at accept time
    assign in_ext   = {{(SUM_W-VAL_W){s_axis_tdata[VAL_W-1]}}, s_axis_tdata};
    assign n_sum_in = s_axis_tuser ? r_sum : r_sum + in_ext;
    assign seen_inc = r_seen + CNT_W'(1);
    assign n_seen   = (seen_inc > r_win) ? r_win : seen_inc;

    // drop the leaving sample once the store read returns
    always_comb begin
        take       = r_do_leave && !r_rd.miss;
        n_sum      = take ? r_sum - {{(SUM_W-VAL_W){r_rd.value[VAL_W-1]}}, r_rd.value}
                          : r_sum;
        n_cnt      = (take && (r_cnt != '0)) ? r_cnt - CNT_W'(1) : r_cnt;
        n_res_miss = (r_seen < r_win) || (n_cnt == '0);
        n_mag      = n_sum[SUM_W-1] ? SUM_W'(0) - n_sum : n_sum;
        n_wp       = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + AW'(1);
    end

    // one restoring division step
    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
    end

    // sign and saturate the quotient magnitude
    always_comb begin
        if (r_neg) begin
            if (r_quo > SUM_W'(40'h0080000000)) begin
                n_mean = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                n_mean = VAL_W'(0) - r_quo[VAL_W-1:0];
            end
        end else if (r_quo > SUM_W'(40'h007FFFFFFF)) begin
            n_mean = {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            n_mean = r_quo[VAL_W-1:0];
        end
    end

    assign load_out = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_UPDATE;
            S_UPDATE: n_state = n_res_miss ? S_DONE : S_DIV;
            S_DIV:    if (r_iter == ITER_W'(SUM_W - 1)) n_state = S_DONE;
            S_DONE:   if (load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // store: read the leaving entry at accept, write the new one in the next (update) state,
    // so the same entry is never read and written in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_mem[r_wp] <= r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_seen      <= '0;
            r_win       <= CNT_W'(1);
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win  <= n_win;
                r_wp   <= '0;
                r_sum  <= '0;
                r_cnt  <= '0;
                r_seen <= '0;
            end else if (accept) begin
                r_sum  <= n_sum_in;
                r_cnt  <= r_cnt + CNT_W'(!s_axis_tuser);
                r_seen <= n_seen;
            end else if (r_state == S_UPDATE) begin
                // restart the series after its last sample
                if (r_last) begin
                    r_wp   <= '0;
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_seen <= '0;
                end else begin
                    r_wp  <= n_wp;
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                end
            end
            if (r_state == S_UPDATE) begin
                r_iter <= '0;
            end else if (r_state == S_DIV) begin
                r_iter <= r_iter + ITER_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.value <= s_axis_tdata;
            r_in.miss  <= s_axis_tuser;
            r_last     <= s_axis_tlast;
            r_do_leave <= (r_seen >= r_win);
        end
        if (r_state == S_UPDATE) begin
            r_res_miss <= n_res_miss;
            r_rem      <= '0;
            r_den      <= n_cnt;
            if (n_res_miss) begin
                r_quo <= '0;
                r_neg <= 1'b0;
            end else begin
                r_quo <= n_mag;
                r_neg <= n_sum[SUM_W-1];
            end
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
        if (load_out) begin
            r_out_data <= n_mean;
            r_out_miss <= r_res_miss;
        end
    end

endmodule

// ===== hw/rtl/rwm_checker.sv =====
// Port-level checks for the rolling window mean unit, bound to the top level.
// Depends on rwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rwm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [rwm_pkg::VAL_W-1:0]   m_axis_tdata,
    input  logic                        m_axis_tuser
);
    import rwm_pkg::*;

    // hold a stalled result
    `RWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a missing mean carries zero
    `RWM_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == VAL_W'(0))

    // one request in flight: input side closes right after a request
    `RWM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no result straight out of reset
    `RWM_ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid)

endmodule

bind rolling_window_mean_unit rwm_checker u_rwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
